// File: rtl/sorted_priority_queue_modes_top_assert.svh
// Assertion macros for the sorted priority queue RTL.
// No dependencies; files that assert include this header.
`ifndef SORTED_PRIORITY_QUEUE_MODES_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_MODES_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is held.
`define SPQM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spqm assertion failed");
// Same, with a caller message.
`define SPQM_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define SPQM_ASSERT(lbl, prop)
`define SPQM_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// File: rtl/spqm_pkg.sv
// Shared types, codes and mode decode for the sorted priority queue.
// No dependencies.
package spqm_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned FILL_W    = 5;

  // order_mode codes
  localparam logic [MODE_W-1:0] MODE_ASC_BEFORE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DESC_AFTER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ASC_AFTER   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DESC_BEFORE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ASC_AFTER_B = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RESET       = MODE_ASC_BEFORE;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_PEEK   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Condition for the insert scan to move past a stored entry e.
  typedef enum logic [1:0] {
    WALK_LT = 2'd0,  // e < x
    WALK_GT = 2'd1,  // e > x
    WALK_LE = 2'd2   // e <= x
  } walk_e;

  // Scan state handed from cell to cell during an insert.
  typedef enum logic [1:0] {
    SCAN_WALK = 2'd0,
    SCAN_EQ   = 2'd1,
    SCAN_STOP = 2'd2
  } scan_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2   // every cell takes its right neighbor
  } cell_op_e;

  typedef struct packed {
    walk_e walk;
    logic  eq_skip;      // step past a run of equals after the scan stops
    logic  back_remove;  // remove takes the tail
  } mode_ctl_t;

  typedef struct packed {
    cell_op_e           op;
    walk_e              walk;
    logic               eq_skip;
    logic signed [31:0] value;
  } cell_ctl_t;

  function automatic mode_ctl_t decode_mode(input logic [MODE_W-1:0] mode);
    mode_ctl_t m;
    m = '{walk: WALK_LT, eq_skip: 1'b0, back_remove: 1'b0};
    unique case (mode) inside
      MODE_DESC_AFTER:  m = '{walk: WALK_GT, eq_skip: 1'b1, back_remove: 1'b0};
      MODE_ASC_AFTER:   m = '{walk: WALK_LE, eq_skip: 1'b0, back_remove: 1'b1};
      MODE_DESC_BEFORE: m = '{walk: WALK_GT, eq_skip: 1'b0, back_remove: 1'b1};
      MODE_ASC_AFTER_B: m = '{walk: WALK_LT, eq_skip: 1'b1, back_remove: 1'b1};
      default:          m = '{walk: WALK_LT, eq_skip: 1'b0, back_remove: 1'b0};
    endcase
    return m;
  endfunction

endpackage

// File: rtl/spqm_cell.sv
// One slot of the sorted queue: holds one entry, compares it against the
// incoming value and shifts with its neighbors. Depends on spqm_pkg.
module spqm_cell import spqm_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic               clk_i,
  input  cell_ctl_t          ctl_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic signed [31:0] left_val_i,
  input  logic signed [31:0] right_val_i,
  input  scan_e              scan_i,
  output scan_e              scan_o,
  output logic signed [31:0] val_o,
  output logic signed [31:0] tail_o
);

  localparam logic [CNT_W-1:0] IdxC   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IdxP1C = CNT_W'(IDX + 1);

  logic signed [31:0] val_q, val_d;
  logic live, last, walk, same, lt_ex, lt_xe;

  assign live  = IdxC < count_i;
  assign last  = count_i == IdxP1C;
  assign lt_ex = val_q < ctl_i.value;
  assign lt_xe = ctl_i.value < val_q;

  always_comb begin
    case (ctl_i.walk)
      WALK_GT: walk = live && lt_xe;
      WALK_LE: walk = live && !lt_xe;
      default: walk = live && lt_ex;
    endcase
  end

  assign same = live && (val_q == ctl_i.value);

  always_comb begin
    case (scan_i)
      SCAN_WALK: begin
        if (walk)                       scan_o = SCAN_WALK;
        else if (ctl_i.eq_skip && same) scan_o = SCAN_EQ;
        else                            scan_o = SCAN_STOP;
      end
      SCAN_EQ: scan_o = same ? SCAN_EQ : SCAN_STOP;
      default: scan_o = SCAN_STOP;
    endcase
  end

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (scan_i == SCAN_STOP)      val_d = left_val_i;   // behind the slot
        else if (scan_o == SCAN_STOP) val_d = ctl_i.value;  // the slot itself
      end
      CELL_SHIFT: val_d = right_val_i;
      default:    val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign tail_o = last ? val_q : '0;

endmodule

// File: rtl/sorted_priority_queue_modes_top.sv
// Sorted priority queue with selectable ordering, built as a row of cells.
// Depends on spqm_pkg, spqm_cell and sorted_priority_queue_modes_top_assert.svh.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, kind_i, value_i   | request in
//  out     | out_valid_o/out_ready_i, status_o,       | result out
//          | front_value_o, removed_value_o,          |
//          | fill_count_o                             |
//  cfg     | cfg_we_i, cfg_wdata_i (order_mode)       | write only
//
// Each request is first captured; then, in the execute step, every cell
// compares and shifts in parallel and the result registers load.
// A new request is taken while the previous result waits at the output;
// the execute cycle stalls only while that result is still held.
// Reset clears the fill count, mode (to 1) and handshake state; cell
// contents are not reset and are never read beyond the fill count.
`include "sorted_priority_queue_modes_top_assert.svh"

module sorted_priority_queue_modes_top import spqm_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MODE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic signed [31:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  front_value_o,
  output logic signed [31:0]  removed_value_o,
  output logic [FILL_W-1:0]   fill_count_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);

  // Control state
  logic               busy_q;
  logic               out_valid_q;
  logic [MODE_W-1:0]  mode_q;
  logic [CNT_W-1:0]   count_q, count_d;

  // Captured request
  kind_e              kind_q;
  logic signed [31:0] value_q;

  // Result registers
  status_e            status_q, status_d;
  logic signed [31:0] front_q, front_d;
  logic signed [31:0] removed_q, removed_d;
  logic [FILL_W-1:0]  fill_q, fill_d;

  logic accept, exec, empty, full;
  mode_ctl_t mctl;
  cell_ctl_t cctl;

  // Cell chain
  logic signed [31:0] val_w  [DEPTH];
  logic signed [31:0] tail_w [DEPTH];
  scan_e              scan_w [DEPTH+1];
  logic signed [31:0] tail_val, front_nxt;
  logic [CNT_W+FILL_W-1:0] fill_wide;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  // Execute once the result slot is free or being drained this cycle.
  assign exec       = busy_q && (!out_valid_q || out_ready_i);
  assign empty      = count_q == '0;
  assign full       = count_q >= DepthC;
  assign mctl       = decode_mode(mode_q);

  always_comb begin
    cctl.op      = CELL_HOLD;
    cctl.walk    = mctl.walk;
    cctl.eq_skip = mctl.eq_skip;
    cctl.value   = value_q;
    if (exec) begin
      case (kind_q)
        KIND_INSERT: if (!full) cctl.op = CELL_INSERT;
        KIND_REMOVE: if (!empty && !mctl.back_remove) cctl.op = CELL_SHIFT;
        default:     cctl.op = CELL_HOLD;
      endcase
    end
  end

  assign scan_w[0] = SCAN_WALK;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = val_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = val_w[i+1];
    end
    spqm_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cctl),
      .count_i     (count_q),
      .left_val_i  (left_v),
      .right_val_i (right_v),
      .scan_i      (scan_w[i]),
      .scan_o      (scan_w[i+1]),
      .val_o       (val_w[i]),
      .tail_o      (tail_w[i])
    );
  end

  // Only the cell at count-1 drives a nonzero tail.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | tail_w[i];
    end
  end

  // Head entry after this cycle's cell update.
  always_comb begin
    if (cctl.op == CELL_INSERT && scan_w[1] == SCAN_STOP) begin
      front_nxt = value_q;
    end else if (cctl.op == CELL_SHIFT) begin
      front_nxt = val_w[1];
    end else begin
      front_nxt = val_w[0];
    end
  end

  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    removed_d = '0;
    case (kind_q)
      KIND_INSERT: begin
        if (full) status_d = ST_FULL;
        else      count_d  = count_q + CNT_W'(1);
      end
      KIND_PEEK: begin
        if (empty) status_d = ST_EMPTY;
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d   = count_q - CNT_W'(1);
          removed_d = mctl.back_remove ? tail_val : val_w[0];
        end
      end
      default: count_d = '0;
    endcase
    front_d   = (count_d != '0) ? front_nxt : '0;
    fill_wide = {{FILL_W{1'b0}}, count_d};
    fill_d    = fill_wide[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_RESET;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(kind_i);
      value_q <= value_i;
    end
    if (exec) begin
      status_q  <= status_d;
      front_q   <= front_d;
      removed_q <= removed_d;
      fill_q    <= fill_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign front_value_o   = front_q;
  assign removed_value_o = removed_q;
  assign fill_count_o    = fill_q;

  `SPQM_ASSERT(a_count_bound, count_q <= DepthC)
  `SPQM_ASSERT_MSG(a_full_keeps_count,
      exec && kind_q == KIND_INSERT && full |=> count_q == $past(count_q),
      "rejected insert changed fill count")
  `SPQM_ASSERT(a_exec_gives_result, exec |=> out_valid_q)
  `SPQM_ASSERT_MSG(a_bad_status_no_removed,
      out_valid_q && status_q != ST_OK |-> removed_q == '0,
      "removed value set on failed request")

endmodule
